[src/fdc_pkg.sv]
package fdc_pkg;

	localparam int DATA_W = 32;
	localparam int FUNC_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int COEF_A_W = 17;
	localparam int LIMIT_W = 31;
	localparam int FRAC_W = 16;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [FUNC_W-1:0] func_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam func_t FUNC_UPDATE = 2'd0;
	localparam func_t FUNC_RESET = 2'd1;
	localparam func_t FUNC_MERGE = 2'd2;

	localparam cfg_idx_t REG_COEF_A = 2'd0;
	localparam cfg_idx_t REG_COEF_B = 2'd1;
	localparam cfg_idx_t REG_DRIVE_LIMIT = 2'd2;

	localparam data_t DATA_MAX = 32'sh7fff_ffff;
	localparam data_t DATA_MIN = 32'sh8000_0000;

endpackage

[src/filtered_derivative_control_top.sv]
// Filtered derivative controller with a first-order low-pass filter.
// Command channel (cmd_valid, cmd_stall): one transaction carries func, setpoint,
// measurement and merge_value. An update computes drive from the error difference
// and the previous drive, clamped to plus or minus drive_limit; a reset clears the
// history; a merge loads the previous drive for bumpless transfer.
// Result channel (res_valid, res_stall): every command gives exactly one result
// transaction holding the stored previous drive after that command.
// The command is registered at acceptance and its result is registered into the
// result register once that register is free, so a stalled result delays it.
// One command is taken every cycle unless the result is stalled; the loop through
// the previous drive register, both multipliers, the sum and the clamp is combinational.
// When the receiver stalls, the result register holds, the command register
// fills, and only then is cmd_stall raised.
// The configuration registers are written through cfg_wr_en, cfg_index and cfg_data;
// the user must write them only while the block is idle; it does not enforce this.
// Reset clears the coefficients, the limit, the history and both valid flags.
module filtered_derivative_control_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  fdc_pkg::cfg_idx_t                   cfg_index,
	input  logic [fdc_pkg::DATA_W-1:0]          cfg_data,
	input  logic                                cmd_valid,
	output logic                                cmd_stall,
	input  fdc_pkg::func_t                      func,
	input  fdc_pkg::data_t                      setpoint,
	input  fdc_pkg::data_t                      measurement,
	input  fdc_pkg::data_t                      merge_value,
	output logic                                res_valid,
	input  logic                                res_stall,
	output fdc_pkg::data_t                      drive
);
	import fdc_pkg::*;

	localparam int ERR_W = DATA_W + 1;
	localparam int PA_W = COEF_A_W + 1 + DATA_W;
	localparam int PB_W = DATA_W + ERR_W;
	localparam int PA_SH_W = PA_W - FRAC_W;
	localparam int PB_SH_W = PB_W - FRAC_W;
	localparam int SUM_W = PB_SH_W + 1;

	logic [COEF_A_W-1:0] coef_a_q;
	data_t               coef_b_q;
	logic [LIMIT_W-1:0]  drive_limit_q;

	data_t prev_error_q;
	data_t prev_drive_q;
	logic  first_q;

	logic  valid_s1;
	func_t func_s1;
	data_t setpoint_s1;
	data_t measurement_s1;
	data_t merge_s1;

	logic  res_valid_q;
	data_t drive_q;

	logic advance;
	logic cmd_take;

	logic signed [ERR_W-1:0]   err_full;
	data_t                     err_sat;
	logic signed [ERR_W-1:0]   diff;
	logic signed [PA_W-1:0]    prod_a;
	logic signed [PB_W-1:0]    prod_b;
	logic signed [PA_SH_W-1:0] prod_a_sh;
	logic signed [PB_SH_W-1:0] prod_b_sh;
	logic signed [SUM_W-1:0]   sum;
	logic signed [SUM_W-1:0]   lim_pos;
	logic signed [SUM_W-1:0]   lim_neg;
	logic signed [SUM_W-1:0]   filt;
	data_t                     upd_drive;

	data_t next_error;
	data_t next_drive;
	logic  next_first;

	assign advance = valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = valid_s1 && !advance;
	assign cmd_take = cmd_valid && !cmd_stall;

	assign res_valid = res_valid_q;
	assign drive = drive_q;

	// Error is saturated to the signed 32-bit range before use.
	assign err_full = {setpoint_s1[DATA_W-1], setpoint_s1}
		- {measurement_s1[DATA_W-1], measurement_s1};
	assign err_sat = (err_full[ERR_W-1] != err_full[ERR_W-2])
		? (err_full[ERR_W-1] ? DATA_MIN : DATA_MAX) : err_full[DATA_W-1:0];
	assign diff = {err_sat[DATA_W-1], err_sat} - {prev_error_q[DATA_W-1], prev_error_q};

	assign prod_a = $signed({1'b0, coef_a_q}) * prev_drive_q;
	assign prod_b = coef_b_q * diff;
	assign prod_a_sh = prod_a[PA_W-1:FRAC_W];
	assign prod_b_sh = prod_b[PB_W-1:FRAC_W];
	assign sum = {{(SUM_W-PA_SH_W){prod_a_sh[PA_SH_W-1]}}, prod_a_sh}
		+ {prod_b_sh[PB_SH_W-1], prod_b_sh};

	assign lim_pos = $signed({{(SUM_W-LIMIT_W){1'b0}}, drive_limit_q});
	assign lim_neg = -lim_pos;
	assign filt = first_q ? '0 : sum;

	always_comb begin
		if (filt > lim_pos) begin
			upd_drive = lim_pos[DATA_W-1:0];
		end else if (filt < lim_neg) begin
			upd_drive = lim_neg[DATA_W-1:0];
		end else begin
			upd_drive = filt[DATA_W-1:0];
		end
	end

	always_comb begin
		next_error = prev_error_q;
		next_drive = prev_drive_q;
		next_first = first_q;
		case (func_s1)
			FUNC_UPDATE: begin
				next_error = err_sat;
				next_drive = upd_drive;
				next_first = 1'b0;
			end
			FUNC_RESET: begin
				next_error = '0;
				next_drive = '0;
				next_first = 1'b1;
			end
			FUNC_MERGE: begin
				next_drive = merge_s1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q <= '0;
			coef_b_q <= '0;
			drive_limit_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_COEF_A: coef_a_q <= cfg_data[COEF_A_W-1:0];
				REG_COEF_B: coef_b_q <= cfg_data;
				REG_DRIVE_LIMIT: drive_limit_q <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
			prev_error_q <= '0;
			prev_drive_q <= '0;
			first_q <= 1'b1;
		end else begin
			if (cmd_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
				prev_error_q <= next_error;
				prev_drive_q <= next_drive;
				first_q <= next_first;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			func_s1 <= func;
			setpoint_s1 <= setpoint;
			measurement_s1 <= measurement;
			merge_s1 <= merge_value;
		end
		if (advance) begin
			drive_q <= next_drive;
		end
	end

	// The offered result always mirrors the stored previous drive.
	a_drive_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (drive_q == prev_drive_q))
		else $error("result drive differs from stored previous drive");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (valid_s1 && res_valid_q && res_stall))
		else $error("command stalled without a blocked result");

	a_first_update_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (func_s1 == FUNC_UPDATE) && first_q) |=> (drive_q == '0))
		else $error("first update after history reset did not drive zero");

endmodule

[tb/filtered_derivative_control_checker.sv]
module filtered_derivative_control_checker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  fdc_pkg::cfg_idx_t        cfg_index,
	input  logic [fdc_pkg::DATA_W-1:0] cfg_data,
	input  logic                     cmd_valid,
	input  logic                     cmd_stall,
	input  fdc_pkg::func_t           func,
	input  fdc_pkg::data_t           setpoint,
	input  fdc_pkg::data_t           measurement,
	input  fdc_pkg::data_t           merge_value,
	input  logic                     res_valid,
	input  logic                     res_stall,
	input  fdc_pkg::data_t           drive,
	output int                       outstanding,
	output int                       errors,
	output int                       results_checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import fdc_pkg::*;

	logic [COEF_A_W-1:0] filt_weight = '0;
	data_t               diff_gain = '0;
	logic [LIMIT_W-1:0]  drive_cap = '0;

	data_t last_error = '0;
	data_t last_drive = '0;
	logic  awaiting_first = 1'b1;

	data_t drive_q[$];
	data_t want;
	int    mismatches = 0;
	int    seen = 0;

	function automatic data_t advance_controller(func_t f, data_t sp, data_t ms, data_t mv);
		longint err;
		longint change;
		longint lag_term;
		longint gain_term;
		longint drv;
		longint cap;
		case (f)
			FUNC_UPDATE: begin
				err = longint'(sp) - longint'(ms);
				if (err > longint'(DATA_MAX)) err = longint'(DATA_MAX);
				if (err < longint'(DATA_MIN)) err = longint'(DATA_MIN);
				if (awaiting_first) begin
					awaiting_first = 1'b0;
					drv = 0;
				end else begin
					change = err - longint'(last_error);
					lag_term = longint'(filt_weight) * longint'(last_drive);
					gain_term = longint'(diff_gain) * change;
					drv = (lag_term >>> FRAC_W) + (gain_term >>> FRAC_W);
				end
				cap = longint'(drive_cap);
				if (drv > cap) drv = cap;
				if (drv < -cap) drv = -cap;
				last_error = data_t'(err[DATA_W-1:0]);
				last_drive = data_t'(drv[DATA_W-1:0]);
			end
			FUNC_RESET: begin
				last_error = '0;
				last_drive = '0;
				awaiting_first = 1'b1;
			end
			FUNC_MERGE: begin
				last_drive = mv;
			end
			default: begin
			end
		endcase
		return last_drive;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_weight = '0;
			diff_gain = '0;
			drive_cap = '0;
			last_error = '0;
			last_drive = '0;
			awaiting_first = 1'b1;
			drive_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_COEF_A: filt_weight = cfg_data[COEF_A_W-1:0];
					REG_COEF_B: diff_gain = data_t'(cfg_data);
					REG_DRIVE_LIMIT: drive_cap = cfg_data[LIMIT_W-1:0];
					default: begin
					end
				endcase
			end
			if (res_valid && !res_stall) begin
				if (drive_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transaction: drive %h", drive);
				end else begin
					want = drive_q.pop_front();
					seen++;
					if (drive !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("drive mismatch on result %0d: expected %h, actual %h",
								seen, want, drive);
					end
				end
			end
			if (cmd_valid && !cmd_stall)
				drive_q.push_back(advance_controller(func, setpoint, measurement, merge_value));
			outstanding <= drive_q.size();
		end
		errors <= mismatches;
		results_checked <= seen;
	end

endmodule

[tb/filtered_derivative_control_top_tb.sv]
module filtered_derivative_control_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fdc_pkg::*;

	localparam func_t FUNC_UNUSED = 2'd3;
	localparam int PHASE_ITEMS = 100;
	localparam int RANDOM_PHASES = 6;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	cfg_idx_t    cfg_index = REG_COEF_A;
	logic [DATA_W-1:0] cfg_data = '0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	func_t       func = FUNC_UPDATE;
	data_t       setpoint = '0;
	data_t       measurement = '0;
	data_t       merge_value = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	data_t       drive;

	int outstanding;
	int errors;
	int results_checked;

	bit gaps_on = 1'b0;
	bit stall_on = 1'b0;
	int n_update = 0;
	int n_reset = 0;
	int n_merge = 0;
	int n_unused = 0;
	int n_settings = 0;

	filtered_derivative_control_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.func        (func),
		.setpoint    (setpoint),
		.measurement (measurement),
		.merge_value (merge_value),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.drive       (drive)
	);

	filtered_derivative_control_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.cmd_valid       (cmd_valid),
		.cmd_stall       (cmd_stall),
		.func            (func),
		.setpoint        (setpoint),
		.measurement     (measurement),
		.merge_value     (merge_value),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.drive           (drive),
		.outstanding     (outstanding),
		.errors          (errors),
		.results_checked (results_checked)
	);

	always #2 clk = ~clk;

	function automatic data_t pick_value();
		case ($urandom_range(0, 9))
			0: return DATA_MAX;
			1: return DATA_MIN;
			2: return '0;
			3: return data_t'(-1);
			4, 5, 6: return data_t'(int'($urandom_range(0, 2097152)) - 1048576);
			default: return data_t'($urandom);
		endcase
	endfunction

	function automatic func_t pick_func();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) return FUNC_UPDATE;
		if (r < 85) return FUNC_MERGE;
		if (r < 92) return FUNC_RESET;
		return FUNC_UNUSED;
	endfunction

	task automatic send_cmd(func_t f, data_t sp, data_t ms, data_t mv);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		func <= f;
		setpoint <= sp;
		measurement <= ms;
		merge_value <= mv;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		case (f)
			FUNC_UPDATE: n_update++;
			FUNC_RESET: n_reset++;
			FUNC_MERGE: n_merge++;
			default: n_unused++;
		endcase
	endtask

	task automatic wait_idle();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// All three registers are written back to back once every result transaction is in.
	task automatic configure(logic [COEF_A_W-1:0] a, data_t b, logic [LIMIT_W-1:0] lim);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_COEF_A;
		cfg_data <= DATA_W'(a);
		@(posedge clk);
		cfg_index <= REG_COEF_B;
		cfg_data <= b;
		@(posedge clk);
		cfg_index <= REG_DRIVE_LIMIT;
		cfg_data <= DATA_W'(lim);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		n_settings++;
	endtask

	task automatic configure_random();
		logic [COEF_A_W-1:0] a;
		data_t               b;
		logic [LIMIT_W-1:0]  lim;
		case ($urandom_range(0, 4))
			0: a = '0;
			1: a = COEF_A_W'(65536);
			2: a = '1;
			3: a = COEF_A_W'($urandom_range(0, 65536));
			default: a = COEF_A_W'($urandom_range(60000, 65536));
		endcase
		case ($urandom_range(0, 4))
			0: b = DATA_MIN;
			1: b = DATA_MAX;
			2, 3: b = data_t'(int'($urandom_range(0, 1048576)) - 524288);
			default: b = data_t'($urandom);
		endcase
		case ($urandom_range(0, 4))
			0: lim = '0;
			1: lim = '1;
			2, 3: lim = LIMIT_W'($urandom_range(65536, 67108864));
			default: lim = LIMIT_W'($urandom);
		endcase
		configure(a, b, lim);
	endtask

	initial begin
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_on && $urandom_range(0, 5) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	initial begin
		int   n;
		func_t f;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(COEF_A_W'(32768), 32'sh0001_0000, '1);
		send_cmd(FUNC_UPDATE, 32'sh0064_0000, '0, data_t'($urandom));
		send_cmd(FUNC_UPDATE, DATA_MAX, DATA_MIN, data_t'($urandom));
		send_cmd(FUNC_UPDATE, DATA_MIN, DATA_MAX, data_t'($urandom));
		send_cmd(FUNC_UPDATE, '0, '0, data_t'($urandom));
		send_cmd(FUNC_MERGE, data_t'($urandom), data_t'($urandom), DATA_MAX);
		send_cmd(FUNC_UPDATE, 32'sh0003_0000, 32'sh0001_0000, data_t'($urandom));
		send_cmd(FUNC_MERGE, data_t'($urandom), data_t'($urandom), DATA_MIN);
		send_cmd(FUNC_UPDATE, data_t'(-1), DATA_MAX, data_t'($urandom));
		send_cmd(FUNC_UNUSED, data_t'($urandom), data_t'($urandom), data_t'($urandom));
		send_cmd(FUNC_RESET, data_t'($urandom), data_t'($urandom), data_t'($urandom));
		send_cmd(FUNC_UPDATE, 32'sh0007_0000, 32'sh0002_0000, data_t'($urandom));
		send_cmd(FUNC_UPDATE, 32'sh0001_0000, -32'sh0001_0000, data_t'($urandom));
		send_cmd(FUNC_MERGE, data_t'($urandom), data_t'($urandom), 32'sh1234_5678);

		configure('1, DATA_MIN, LIMIT_W'(65536));
		send_cmd(FUNC_UPDATE, 32'sh0000_0001, '0, data_t'($urandom));
		send_cmd(FUNC_MERGE, data_t'($urandom), data_t'($urandom), DATA_MAX);
		send_cmd(FUNC_UPDATE, '0, 32'sh0005_0000, data_t'($urandom));
		send_cmd(FUNC_UPDATE, DATA_MIN, '0, data_t'($urandom));
		send_cmd(FUNC_UPDATE, DATA_MAX, data_t'(-1), data_t'($urandom));

		configure('0, DATA_MAX, '0);
		send_cmd(FUNC_MERGE, data_t'($urandom), data_t'($urandom), -32'sh0005_0000);
		send_cmd(FUNC_UPDATE, DATA_MAX, DATA_MIN, data_t'($urandom));
		send_cmd(FUNC_UPDATE, 32'sh007b_0000, '0, data_t'($urandom));
		send_cmd(FUNC_RESET, data_t'($urandom), data_t'($urandom), data_t'($urandom));
		send_cmd(FUNC_UPDATE, 32'sh0000_0001, 32'sh0000_0002, data_t'($urandom));

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			configure_random();
			gaps_on = (phase < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
			stall_on = (phase < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
			n = 0;
			while (n < PHASE_ITEMS) begin
				f = pick_func();
				send_cmd(f, pick_value(), pick_value(), pick_value());
				if (f != FUNC_UNUSED) n++;
			end
		end

		wait_idle();
		repeat (4) @(posedge clk);
		$display("covered %0d updates, %0d history resets, %0d merges, %0d unused codes",
			n_update, n_reset, n_merge, n_unused);
		$display("over %0d register settings, with %0d results compared",
			n_settings, results_checked);
		if (errors == 0 && outstanding == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

[sim.f]
src/fdc_pkg.sv
src/filtered_derivative_control_top.sv
tb/filtered_derivative_control_checker.sv
tb/filtered_derivative_control_top_tb.sv
